// ===== rtl/amsa_pkg.sv =====
// Shared types and constants for the multiplexed ADC scan averager.
package amsa_pkg;

    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned SUM_W     = 16;
    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned AVG_W     = 12;
    localparam int unsigned SEL_W     = 4;
    localparam int unsigned LIMIT_W   = 5;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 12;

    localparam logic [LIMIT_W-1:0] LIMIT_MIN = LIMIT_W'(1);
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = LIMIT_W'(16);

    localparam logic [LIMIT_W-1:0] RST_INPUTS_PER_MUX = LIMIT_W'(16);
    localparam logic [LIMIT_W-1:0] RST_MUX_COUNT      = LIMIT_W'(2);
    localparam logic [AVG_W-1:0]   RST_ADC_MAX        = AVG_W'(1023);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUTS_PER_MUX = 2'd0,
        CFG_MUX_COUNT      = 2'd1,
        CFG_ADC_MAX        = 2'd2,
        CFG_UNUSED         = 2'd3
    } t_cfg_idx;

    // Limits are held already clamped to 1..16.
    typedef struct packed {
        logic [LIMIT_W-1:0] inputs_limit;
        logic [LIMIT_W-1:0] mux_limit;
        logic [AVG_W-1:0]   adc_max;
    } t_cfg;

    typedef struct packed {
        logic              hit;
        logic [CHAN_W-1:0] channel;
        logic [SUM_W-1:0]  sum;
        logic [SEL_W-1:0]  node_select;
        logic [SEL_W-1:0]  mux_select;
    } t_result;

endpackage

// ===== rtl/amsa_cfg_regs.sv =====
// Configuration registers with limit clamping.
module amsa_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [amsa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [amsa_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    output amsa_pkg::t_cfg                   o_cfg
);

    amsa_pkg::t_cfg r_cfg;
    logic [amsa_pkg::LIMIT_W-1:0] w_lim_raw;
    logic [amsa_pkg::LIMIT_W-1:0] w_lim;

    assign w_lim_raw = i_cfg_data[amsa_pkg::LIMIT_W-1:0];

    always_comb begin
        if (w_lim_raw == '0) begin
            w_lim = amsa_pkg::LIMIT_MIN;
        end else if (w_lim_raw > amsa_pkg::LIMIT_MAX) begin
            w_lim = amsa_pkg::LIMIT_MAX;
        end else begin
            w_lim = w_lim_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inputs_limit <= amsa_pkg::RST_INPUTS_PER_MUX;
            r_cfg.mux_limit    <= amsa_pkg::RST_MUX_COUNT;
            r_cfg.adc_max      <= amsa_pkg::RST_ADC_MAX;
        end else if (i_cfg_we) begin
            case (amsa_pkg::t_cfg_idx'(i_cfg_index))
                amsa_pkg::CFG_INPUTS_PER_MUX: r_cfg.inputs_limit <= w_lim;
                amsa_pkg::CFG_MUX_COUNT:      r_cfg.mux_limit    <= w_lim;
                amsa_pkg::CFG_ADC_MAX:        r_cfg.adc_max      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/amsa_scan.sv =====
// Scan state: sample filter, settling discard, accumulator and mux stepping.
module amsa_scan #(
    parameter int unsigned AVG_SAMPLES = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic [amsa_pkg::SAMPLE_W-1:0]   i_sample,
    input  amsa_pkg::t_cfg                  i_cfg,
    output amsa_pkg::t_result               o_result
);

    localparam int unsigned CNT_W = $clog2(AVG_SAMPLES + 2);
    localparam logic [CNT_W-1:0] CNT_DONE = CNT_W'(AVG_SAMPLES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(AVG_SAMPLES);

    logic [amsa_pkg::SUM_W-1:0]  r_sum,     n_sum;
    logic [CNT_W-1:0]            r_count,   n_count;
    logic [amsa_pkg::CHAN_W-1:0] r_channel, n_channel;
    logic [amsa_pkg::SEL_W-1:0]  r_node,    n_node;
    logic [amsa_pkg::SEL_W-1:0]  r_mux,     n_mux;

    logic                            w_ok;
    logic                            w_done;
    logic [CNT_W-1:0]                w_count_inc;
    logic [amsa_pkg::SUM_W-1:0]      w_sum_acc;
    logic [amsa_pkg::LIMIT_W-1:0]    w_node_inc;
    logic [amsa_pkg::LIMIT_W-1:0]    w_mux_inc;

    assign w_ok        = i_sample <= amsa_pkg::SAMPLE_W'(i_cfg.adc_max);
    assign w_count_inc = r_count + CNT_W'(1);
    assign w_done      = w_ok && (w_count_inc == CNT_DONE);
    // first valid sample after a switch is only counted, not summed
    assign w_sum_acc   = (r_count != '0) ? r_sum + i_sample : r_sum;
    assign w_node_inc  = amsa_pkg::LIMIT_W'(r_node) + amsa_pkg::LIMIT_W'(1);
    assign w_mux_inc   = amsa_pkg::LIMIT_W'(r_mux) + amsa_pkg::LIMIT_W'(1);

    always_comb begin
        n_sum     = r_sum;
        n_count   = r_count;
        n_channel = r_channel;
        n_node    = r_node;
        n_mux     = r_mux;
        if (w_ok) begin
            n_sum   = w_sum_acc;
            n_count = w_count_inc;
        end
        if (w_done) begin
            n_sum     = '0;
            n_count   = '0;
            n_channel = r_channel + amsa_pkg::CHAN_W'(1);
            if (w_node_inc >= i_cfg.inputs_limit) begin
                n_node = '0;
                if (w_mux_inc >= i_cfg.mux_limit) begin
                    n_mux     = '0;
                    n_channel = '0;
                end else begin
                    n_mux = w_mux_inc[amsa_pkg::SEL_W-1:0];
                end
            end else begin
                n_node = w_node_inc[amsa_pkg::SEL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_count   <= '0;
            r_channel <= '0;
            r_node    <= '0;
            r_mux     <= '0;
        end else if (i_step) begin
            r_sum     <= n_sum;
            r_count   <= n_count;
            r_channel <= n_channel;
            r_node    <= n_node;
            r_mux     <= n_mux;
        end
    end

    assign o_result.hit         = w_done;
    assign o_result.channel     = r_channel;
    assign o_result.sum         = w_sum_acc;
    assign o_result.node_select = n_node;
    assign o_result.mux_select  = n_mux;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("sample count beyond window");

    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CNT_W'(1)) |-> (r_sum == '0))
        else $error("sum not empty at window start");

    a_done_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && w_done) |=> (r_count == '0 && r_sum == '0))
        else $error("window not restarted after average");

endmodule

// ===== rtl/amsa_div.sv =====
// Divide the window sum by the sample count through a reciprocal multiply.
module amsa_div #(
    parameter int unsigned AVG_SAMPLES = 4
) (
    input  logic [amsa_pkg::SUM_W-1:0] i_sum,
    output logic [amsa_pkg::AVG_W-1:0] o_avg
);

    // K = 21 keeps the rounded-up reciprocal exact for 16-bit dividends
    localparam int unsigned K      = 21;
    localparam int unsigned RCP_W  = K + 1;
    localparam int unsigned PROD_W = amsa_pkg::SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << K) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));

    logic [PROD_W-1:0] w_prod;

    assign w_prod = PROD_W'(i_sum) * PROD_W'(RECIP);
    assign o_avg  = w_prod[K +: amsa_pkg::AVG_W];

endmodule

// ===== rtl/adc_mux_scan_averager.sv =====
// Top level of the multiplexed ADC scan averager.
//
// Input channel: one ADC conversion word per handshake (i_in_valid/o_in_ready).
// Words above adc_max are dropped, the first valid word after a channel switch
// is discarded, and the next AVG_SAMPLES valid words are averaged.
// Output channel: one word per completed average (o_out_valid/i_out_ready)
// carrying channel index, truncated mean and the new node/control mux selects.
// A completing input word passes from the input register through the scan
// update into the result register, which drives the output.
// Throughput: one input word per cycle while the receiver does not stall, as the
// scan update between the input and result registers is combinational.
// When the receiver stalls, the result register holds and the input register
// holds its word as well, whether or not it would produce a result;
// o_in_ready drops once both registers are full.
// Reset (synchronous, active low) clears the scan state, both register
// valids and loads the configuration defaults (16 inputs, 2 muxes, max 1023).
// Configuration writes take effect at once; write only while idle.
module adc_mux_scan_averager #(
    parameter int unsigned AVG_SAMPLES = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [amsa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [amsa_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [amsa_pkg::SAMPLE_W-1:0]   i_adc_sample,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [amsa_pkg::CHAN_W-1:0]     o_channel,
    output logic [amsa_pkg::AVG_W-1:0]      o_average,
    output logic [amsa_pkg::SEL_W-1:0]      o_node_select,
    output logic [amsa_pkg::SEL_W-1:0]      o_mux_select
);

    amsa_pkg::t_cfg    w_cfg;
    amsa_pkg::t_result w_res;

    logic                          r_in_valid;
    logic [amsa_pkg::SAMPLE_W-1:0] r_sample;
    logic                          r_out_valid;
    logic [amsa_pkg::CHAN_W-1:0]   r_channel;
    logic [amsa_pkg::SUM_W-1:0]    r_sum;
    logic [amsa_pkg::SEL_W-1:0]    r_node;
    logic [amsa_pkg::SEL_W-1:0]    r_mux;

    logic w_out_free;
    logic w_adv;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;

    amsa_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    amsa_scan #(.AVG_SAMPLES(AVG_SAMPLES)) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_adv),
        .i_sample (r_sample),
        .i_cfg    (w_cfg),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_sample <= i_adc_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_adv && w_res.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res.hit) begin
            r_channel <= w_res.channel;
            r_sum     <= w_res.sum;
            r_node    <= w_res.node_select;
            r_mux     <= w_res.mux_select;
        end
    end

    amsa_div #(.AVG_SAMPLES(AVG_SAMPLES)) u_div (
        .i_sum (r_sum),
        .o_avg (o_average)
    );

    assign o_out_valid   = r_out_valid;
    assign o_channel     = r_channel;
    assign o_node_select = r_node;
    assign o_mux_select  = r_mux;

endmodule
